// ===== hw/rtl/fft_pkg.sv =====
`default_nettype none
package fft_pkg;

	localparam int MAX_LOG2 = 6;
	localparam int MAX_LEN = 1 << MAX_LOG2;
	localparam int ADDR_W = MAX_LOG2;
	localparam int SAMPLE_W = 16;
	localparam int STORE_W = SAMPLE_W + MAX_LOG2 + 1;
	localparam int TW_W = 18;
	localparam int TW_FRAC = 17;
	localparam int PROD_W = STORE_W + TW_W;
	localparam int RND_W = PROD_W + 1 - TW_FRAC;
	localparam int WORD_W = 2 * STORE_W;
	localparam int CNT_W = MAX_LOG2 + 1;

	localparam logic CFG_LOG2_LENGTH = 1'b0;
	localparam logic CFG_INVERSE_MODE = 1'b1;

	typedef struct packed {
		logic signed [TW_W-1:0] cr;
		logic signed [TW_W-1:0] ci;
	} twiddle_t;

	typedef struct packed {
		logic inv;
		logic bypass;
	} bf_ctrl_t;

	function automatic logic [TW_W-1:0] cos_tab(input logic [4:0] i);
		logic [TW_W-1:0] v;
		case (i)
			5'd0: v = 18'd131072;
			5'd1: v = 18'd130441;
			5'd2: v = 18'd128553;
			5'd3: v = 18'd125428;
			5'd4: v = 18'd121095;
			5'd5: v = 18'd115595;
			5'd6: v = 18'd108982;
			5'd7: v = 18'd101320;
			5'd8: v = 18'd92682;
			5'd9: v = 18'd83151;
			5'd10: v = 18'd72820;
			5'd11: v = 18'd61787;
			5'd12: v = 18'd50159;
			5'd13: v = 18'd38048;
			5'd14: v = 18'd25571;
			5'd15: v = 18'd12847;
			default: v = 18'd0;
		endcase
		return v;
	endfunction

	function automatic twiddle_t twiddle(input logic [4:0] k);
		twiddle_t t;
		logic signed [TW_W:0] cr;
		logic signed [TW_W:0] sn;
		logic [5:0] mk;
		mk = 6'd32 - {1'b0, k};
		if (k <= 5'd16) begin
			cr = $signed({1'b0, cos_tab(k)});
			sn = $signed({1'b0, cos_tab(5'd16 - k)});
		end else begin
			cr = -$signed({1'b0, cos_tab(mk[4:0])});
			sn = $signed({1'b0, cos_tab(k - 5'd16)});
		end
		if (cr > 19'sd131071)
			cr = 19'sd131071;
		sn = -sn;
		t.cr = cr[TW_W-1:0];
		t.ci = sn[TW_W-1:0];
		return t;
	endfunction

	function automatic logic signed [STORE_W-1:0] sat_store(input logic signed [RND_W:0] v);
		logic signed [RND_W:0] hi;
		logic signed [RND_W:0] lo;
		hi = (RND_W+1)'((1 << (STORE_W - 1)) - 1);
		lo = -(RND_W+1)'(1 << (STORE_W - 1));
		if (v > hi)
			return hi[STORE_W-1:0];
		else if (v < lo)
			return lo[STORE_W-1:0];
		return v[STORE_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] bitrev(input logic [ADDR_W-1:0] a);
		logic [ADDR_W-1:0] r;
		for (int i = 0; i < ADDR_W; i++)
			r[i] = a[ADDR_W-1-i];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fft_mem.sv =====
`default_nettype none
module fft_mem
	import fft_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WORD_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr0,
	input  wire logic [ADDR_W-1:0] raddr1,
	output logic      [WORD_W-1:0] rdata0,
	output logic      [WORD_W-1:0] rdata1
);

	logic [WORD_W-1:0] mem [MAX_LEN];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/fft_bfly.sv =====
`default_nettype none
module fft_bfly
	import fft_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       mul_en,
	input  wire bf_ctrl_t                   ctrl,
	input  wire twiddle_t                   tw,
	input  wire logic signed [STORE_W-1:0]  e_re,
	input  wire logic signed [STORE_W-1:0]  e_im,
	input  wire logic signed [STORE_W-1:0]  o_re,
	input  wire logic signed [STORE_W-1:0]  o_im,
	output logic signed [STORE_W-1:0]       a_re,
	output logic signed [STORE_W-1:0]       a_im,
	output logic signed [STORE_W-1:0]       b_re,
	output logic signed [STORE_W-1:0]       b_im
);

	logic signed [PROD_W-1:0] rr_s1, ii_s1, ri_s1, ir_s1;
	logic signed [STORE_W-1:0] e_re_s1, e_im_s1, o_re_s1, o_im_s1;
	bf_ctrl_t ctrl_s1;

	logic signed [PROD_W:0] sum_r, sum_i;
	logic signed [PROD_W:0] rnd_r, rnd_i;
	logic signed [RND_W-1:0] pr, pi;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			rr_s1 <= PROD_W'(o_re * tw.cr);
			ii_s1 <= PROD_W'(o_im * tw.ci);
			ri_s1 <= PROD_W'(o_re * tw.ci);
			ir_s1 <= PROD_W'(o_im * tw.cr);
			e_re_s1 <= e_re;
			e_im_s1 <= e_im;
			o_re_s1 <= o_re;
			o_im_s1 <= o_im;
			ctrl_s1 <= ctrl;
		end
	end

	always_comb begin
		if (ctrl_s1.inv) begin
			sum_r = (PROD_W+1)'(rr_s1) + (PROD_W+1)'(ii_s1);
			sum_i = (PROD_W+1)'(ir_s1) - (PROD_W+1)'(ri_s1);
		end else begin
			sum_r = (PROD_W+1)'(rr_s1) - (PROD_W+1)'(ii_s1);
			sum_i = (PROD_W+1)'(ri_s1) + (PROD_W+1)'(ir_s1);
		end
		rnd_r = (sum_r + (PROD_W+1)'(1 << (TW_FRAC - 1))) >>> TW_FRAC;
		rnd_i = (sum_i + (PROD_W+1)'(1 << (TW_FRAC - 1))) >>> TW_FRAC;
		if (ctrl_s1.bypass) begin
			pr = RND_W'(o_re_s1);
			pi = RND_W'(o_im_s1);
		end else begin
			pr = rnd_r[RND_W-1:0];
			pi = rnd_i[RND_W-1:0];
		end
		a_re = sat_store((RND_W+1)'(e_re_s1) + (RND_W+1)'(pr));
		a_im = sat_store((RND_W+1)'(e_im_s1) + (RND_W+1)'(pi));
		b_re = sat_store((RND_W+1)'(e_re_s1) - (RND_W+1)'(pr));
		b_im = sat_store((RND_W+1)'(e_im_s1) - (RND_W+1)'(pi));
	end

endmodule
`default_nettype wire

// ===== hw/rtl/radix2_fft_core.sv =====
`default_nettype none
// Channel   Direction  Contents
// s_axis    in         s_tdata: sample_real, sample_imag
// m_axis    out        m_tdata: result_real, result_imag; m_tlast: last_result
// cfg       in         cfg_we, cfg_index, cfg_data: log2_length, inverse_mode
// Samples are taken only while loading; the n-th sample starts the transform.
// Each butterfly runs through the read, multiply, add and write states, with four
// parallel products; no sample is taken until the frame's last result is on the output.
// Reset clears control state, sets log2_length 6, inverse_mode 0; memory is kept.
// A stall at the output holds the next memory read until the word is taken.
module radix2_fft_core
	import fft_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // sample_real [15:0], sample_imag [31:16]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // result_real [22:0], result_imag [45:23]
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [2:0]  cfg_data
);

	typedef enum logic [2:0] {
		ST_LOAD, ST_BF_RD, ST_BF_MUL, ST_BF_ADD, ST_BF_WR, ST_OUT_RD, ST_OUT_LD
	} state_t;

	state_t state_q;
	logic [2:0] len_q;
	logic inv_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0] stage_q;
	logic [ADDR_W-2:0] bi_q;
	logic [ADDR_W-1:0] oi_q;
	logic [WORD_W-1:0] b_q;
	logic m_tvalid_q, m_tlast_q;
	logic [2*STORE_W-1:0] m_data_q;

	logic [2:0] l_eff;
	logic [CNT_W-1:0] n_m1;
	logic [ADDR_W-1:0] half, jv, e_addr, o_addr;
	logic [ADDR_W-2:0] k_idx;
	logic accept;
	logic mem_we;
	logic [ADDR_W-1:0] waddr, raddr0, raddr1;
	logic [WORD_W-1:0] wdata, rdata0, rdata1;
	logic signed [STORE_W-1:0] in_re, in_im;
	logic signed [STORE_W-1:0] a_re, a_im, b_re, b_im;
	logic signed [STORE_W:0] sc_re, sc_im;
	logic [STORE_W-1:0] out_re, out_im;
	bf_ctrl_t ctrl;

	always_comb begin
		l_eff = (len_q > 3'(MAX_LOG2)) ? 3'(MAX_LOG2) : len_q;
		n_m1 = (CNT_W'(1) << l_eff) - CNT_W'(1);
		half = (stage_q == 3'd0) ? '0 : (ADDR_W'(1) << (stage_q - 3'd1));
		jv = {1'b0, bi_q} & (half - ADDR_W'(1));
		e_addr = ((({1'b0, bi_q} & ~(half - ADDR_W'(1)))) << 1) | jv;
		o_addr = e_addr | half;
		k_idx = jv[ADDR_W-2:0] << (3'(MAX_LOG2) - stage_q);
		ctrl.inv = inv_q;
		ctrl.bypass = (jv == '0);
		accept = s_tvalid && s_tready;
		in_re = STORE_W'($signed(s_tdata[15:0]));
		in_im = STORE_W'($signed(s_tdata[31:16]));
		mem_we = 1'b0;
		waddr = e_addr;
		wdata = {a_im, a_re};
		raddr0 = e_addr;
		raddr1 = o_addr;
		case (state_q)
			ST_LOAD: begin
				mem_we = accept;
				waddr = bitrev(cnt_q[ADDR_W-1:0]) >> (3'(MAX_LOG2) - l_eff);
				wdata = {in_im, in_re};
			end
			ST_BF_ADD: mem_we = 1'b1;
			ST_BF_WR: begin
				mem_we = 1'b1;
				waddr = o_addr;
				wdata = b_q;
			end
			ST_OUT_RD, ST_OUT_LD: raddr0 = oi_q;
			default: ;
		endcase
		sc_re = $signed({rdata0[STORE_W-1], rdata0[STORE_W-1:0]});
		sc_im = $signed({rdata0[WORD_W-1], rdata0[WORD_W-1:STORE_W]});
		if (inv_q && l_eff != 3'd0) begin
			sc_re = (sc_re + ((STORE_W+1)'(1) << (l_eff - 3'd1))) >>> l_eff;
			sc_im = (sc_im + ((STORE_W+1)'(1) << (l_eff - 3'd1))) >>> l_eff;
		end
		out_re = sc_re[STORE_W-1:0];
		out_im = sc_im[STORE_W-1:0];
	end

	fft_mem u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	fft_bfly u_bfly (
		.clk    (clk),
		.mul_en (state_q == ST_BF_MUL),
		.ctrl   (ctrl),
		.tw     (twiddle(k_idx)),
		.e_re   (rdata0[STORE_W-1:0]),
		.e_im   (rdata0[WORD_W-1:STORE_W]),
		.o_re   (rdata1[STORE_W-1:0]),
		.o_im   (rdata1[WORD_W-1:STORE_W]),
		.a_re   (a_re),
		.a_im   (a_im),
		.b_re   (b_re),
		.b_im   (b_im)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			len_q <= 3'd6;
			inv_q <= 1'b0;
			cnt_q <= '0;
			stage_q <= '0;
			bi_q <= '0;
			oi_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tlast_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_LOG2_LENGTH) begin
					len_q <= cfg_data;
					cnt_q <= '0;
				end else if (cfg_index == CFG_INVERSE_MODE) begin
					inv_q <= cfg_data[0];
				end
			end
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (cnt_q == n_m1) begin
							cnt_q <= '0;
							stage_q <= 3'd1;
							bi_q <= '0;
							oi_q <= '0;
							state_q <= (l_eff == 3'd0) ? ST_OUT_RD : ST_BF_RD;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				ST_BF_RD: state_q <= ST_BF_MUL;
				ST_BF_MUL: state_q <= ST_BF_ADD;
				ST_BF_ADD: begin
					b_q <= {b_im, b_re};
					state_q <= ST_BF_WR;
				end
				ST_BF_WR: begin
					if (bi_q == n_m1[ADDR_W-1:1]) begin
						bi_q <= '0;
						if (stage_q == l_eff) begin
							state_q <= ST_OUT_RD;
						end else begin
							stage_q <= stage_q + 3'd1;
							state_q <= ST_BF_RD;
						end
					end else begin
						bi_q <= bi_q + 1'b1;
						state_q <= ST_BF_RD;
					end
				end
				ST_OUT_RD: begin
					if (!m_tvalid_q)
						state_q <= ST_OUT_LD;
				end
				ST_OUT_LD: begin
					m_data_q <= {out_im, out_re};
					m_tvalid_q <= 1'b1;
					m_tlast_q <= ({1'b0, oi_q} == n_m1);
					oi_q <= oi_q + 1'b1;
					state_q <= ({1'b0, oi_q} == n_m1) ? ST_LOAD : ST_OUT_RD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign s_tready = (state_q == ST_LOAD);
	assign m_tvalid = m_tvalid_q;
	assign m_tlast = m_tlast_q;
	assign m_tdata = {2'b00, m_data_q};

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (cnt_q <= n_m1))
		else $error("load count beyond frame length");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cnt_q == n_m1 && !cfg_we) |=> (state_q != ST_LOAD))
		else $error("full frame did not start the transform");

	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BF_RD) |-> (stage_q >= 3'd1 && stage_q <= l_eff))
		else $error("butterfly stage out of range");

	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT_LD) |-> !m_tvalid_q)
		else $error("result word overwritten");

endmodule
`default_nettype wire

// ===== verif/tb_radix2_fft_core.sv =====
`default_nettype none
module tb_radix2_fft_core;
	import fft_pkg::*;

	typedef struct {
		logic signed [22:0] re;
		logic signed [22:0] im;
		logic               last;
	} fft_word_t;

	// Keeps the frame being loaded and the spectra still owed by the core.
	class fft_scoreboard;
		fft_word_t          pending[$];
		longint             frame_re[64];
		longint             frame_im[64];
		int                 fill;
		int                 len_log2;
		bit                 inv_mode;
		int                 errors;

		function new();
			fill = 0;
			len_log2 = 6;
			inv_mode = 0;
			errors = 0;
		endfunction

		function void set_reg(logic index, logic [2:0] value);
			if (index == CFG_LOG2_LENGTH) begin
				len_log2 = value;
				fill = 0;
			end else begin
				inv_mode = value[0];
			end
		endfunction

		function void twiddle_q17(int k, output longint cr, output longint ci);
			real a;
			a = 2.0 * 3.141592653589793 * k / 64.0;
			cr = longint'($floor($cos(a) * 131072.0 + 0.5));
			ci = longint'($floor(-$sin(a) * 131072.0 + 0.5));
			if (cr > 131071) cr = 131071;
			if (ci > 131071) ci = 131071;
			if (cr < -131072) cr = -131072;
			if (ci < -131072) ci = -131072;
		endfunction

		function longint clip_store(longint v);
			if (v > 4194303) return 4194303;
			if (v < -4194304) return -4194304;
			return v;
		endfunction

		function void note_sample(logic signed [15:0] re, logic signed [15:0] im);
			int lg, n, addr, st, half, b, j;
			longint er, ei, orr, oi, pr, pi, cr, ci, h;
			fft_word_t w;
			lg = (len_log2 > 6) ? 6 : len_log2;
			n = 1 << lg;
			if (fill >= n) fill = 0;
			addr = 0;
			for (int i = 0; i < lg; i++)
				if (fill[i]) addr |= 1 << (lg - 1 - i);
			frame_re[addr] = re;
			frame_im[addr] = im;
			fill++;
			if (fill < n) return;
			fill = 0;
			for (st = 1; st <= lg; st++) begin
				half = 1 << (st - 1);
				for (b = 0; b < n; b += 2 * half)
					for (j = 0; j < half; j++) begin
						er = frame_re[b+j];
						ei = frame_im[b+j];
						orr = frame_re[b+j+half];
						oi = frame_im[b+j+half];
						if (j == 0) begin
							pr = orr;
							pi = oi;
						end else begin
							twiddle_q17(j << (6 - st), cr, ci);
							if (inv_mode) begin
								pr = (orr * cr + oi * ci + 65536) >>> 17;
								pi = (oi * cr - orr * ci + 65536) >>> 17;
							end else begin
								pr = (orr * cr - oi * ci + 65536) >>> 17;
								pi = (orr * ci + oi * cr + 65536) >>> 17;
							end
						end
						frame_re[b+j] = clip_store(er + pr);
						frame_im[b+j] = clip_store(ei + pi);
						frame_re[b+j+half] = clip_store(er - pr);
						frame_im[b+j+half] = clip_store(ei - pi);
					end
			end
			for (int i = 0; i < n; i++) begin
				er = frame_re[i];
				ei = frame_im[i];
				if (inv_mode && lg > 0) begin
					h = 1 << (lg - 1);
					er = (er + h) >>> lg;
					ei = (ei + h) >>> lg;
				end
				w.re = er[22:0];
				w.im = ei[22:0];
				w.last = (i == n - 1);
				pending.push_back(w);
			end
		endfunction

		task automatic check_result(logic [47:0] data, logic last);
			fft_word_t w;
			if (pending.size() == 0) begin
				report_mismatch("result word with nothing expected");
				return;
			end
			w = pending.pop_front();
			if (data[22:0] !== w.re)
				report_mismatch($sformatf("real %0d, expected %0d",
					$signed(data[22:0]), w.re));
			if (data[45:23] !== w.im)
				report_mismatch($sformatf("imag %0d, expected %0d",
					$signed(data[45:23]), w.im));
			if (last !== w.last)
				report_mismatch($sformatf("tlast %0b, expected %0b", last, w.last));
		endtask

		task automatic report_mismatch(string msg);
			errors++;
			$display("%0t mismatch: %s", $realtime, msg);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we;
	logic        cfg_index;
	logic [2:0]  cfg_data;

	fft_scoreboard sb;
	int idle_cycles = 0;
	bit sending_done;
	bit long_hold;

	radix2_fft_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Registers are only written once every owed result word has been taken.
	task automatic write_reg(logic index, logic [2:0] value);
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(index, value);
		@(posedge clk);
	endtask

	task automatic send_sample(logic [15:0] re, logic [15:0] im, bit lazy);
		int gap;
		gap = lazy ? $urandom_range(0, 12) : 0;
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {im, re};
		do @(posedge clk); while (!s_tready);
		sb.note_sample(re, im);
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return $urandom();
		endcase
	endfunction

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (2 * 64 * 6 + 300) @(posedge clk);
	endtask

	task automatic send_frame(int lg, bit inv, int count);
		write_reg(CFG_LOG2_LENGTH, lg[2:0]);
		write_reg(CFG_INVERSE_MODE, inv);
		for (int i = 0; i < count; i++)
			send_sample(pick_value(), pick_value(), 1);
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		sending_done = 0;
		long_hold = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: length one, extremes, an oversized length and a partial frame.
		write_reg(CFG_LOG2_LENGTH, 3'd0);
		send_sample(16'h8000, 16'h7fff, 0);
		send_sample(16'h7fff, 16'h8000, 0);
		write_reg(CFG_INVERSE_MODE, 1'b1);
		send_sample(16'hffff, 16'h0001, 0);
		drain();
		write_reg(CFG_LOG2_LENGTH, 3'd2);
		send_sample(16'h7fff, 16'h7fff, 0);
		send_sample(16'h7fff, 16'h7fff, 0);
		write_reg(CFG_INVERSE_MODE, 1'b0);
		send_sample(16'h8000, 16'h8000, 0);
		send_sample(16'h7fff, 16'h8000, 0);
		drain();
		write_reg(CFG_LOG2_LENGTH, 3'd3);
		send_sample(16'h1234, 16'h4321, 0);
		send_sample(16'h0bad, 16'hf00d, 0);
		write_reg(CFG_LOG2_LENGTH, 3'd1);
		send_sample(16'h8000, 16'h8000, 0);
		send_sample(16'h8000, 16'h8000, 0);
		drain();
		send_frame(7, 0, 64);
		// The next frame is offered while the receiver holds off.
		for (int i = 0; i < 64; i++)
			send_sample(pick_value(), pick_value(), 0);
		drain();
		send_frame(6, 1, 64);
		drain();
		// Random frames, mostly short, each with its own length and direction.
		while (sb.pending.size() < 1000 && idle_cycles >= 0) begin : random_part
			int lg, total;
			total = 0;
			repeat (30) begin
				lg = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
				send_frame(lg, $urandom_range(0, 1), (lg > 6 ? 64 : (1 << lg)));
				total += (lg > 6 ? 64 : (1 << lg));
				drain();
				if (total > 16) break;
			end
			break;
		end
		sending_done = 1;
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			if (!long_hold && sb.pending.size() > 40) begin
				long_hold = 1;
				m_tready <= 0;
				repeat (2000) @(posedge clk);
			end
			if ($urandom_range(0, 1)) begin
				m_tready <= 0;
				repeat ($urandom_range(0, 12)) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule
`default_nettype wire
